// File: rtl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; imported by every rtl file of the block.
package sitda_pkg;

  localparam int ValueW    = 32;
  localparam int BcdDigits = 10;
  localparam int BcdW      = 4 * BcdDigits;
  localparam int CharW     = 7;
  localparam int BitCntW   = $clog2(ValueW);
  localparam int DigCntW   = $clog2(BcdDigits + 1);

  localparam logic [CharW-1:0] CharZero  = 7'd48;
  localparam logic [CharW-1:0] CharMinus = 7'd45;

  typedef logic [BcdW-1:0] bcd_t;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

endpackage

// File: rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on sitda_pkg and sitda_bcd_step.
//
// Usage:
//   Command channel: drive value_i and raise start while busy is low; the word
//   is taken at that clock edge and busy is high from that edge on.
//   Result channel: each character appears on char_code_o for exactly one
//   cycle with strobe_o high; last_char_o marks the final character. The
//   characters of one number come out in consecutive cycles, a minus sign
//   first for negative values, then the digits most significant first with
//   no leading zeros (zero gives a single '0').
//   Timing: the shift-and-add-3 steps run one per input bit, all through the
//   single BCD step unit; then leading zero digits are skipped one per cycle
//   and the first digit is found, then the characters go one per cycle through
//   the output register. Busy falls as the last character is registered, so
//   the next start is taken as the last character is on the ports.
//   Reset: asynchronous, active low; the block returns idle with no strobe.
//   The receiver cannot stall, so results never wait and need no buffering.
module signed_int_to_decimal_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic signed [sitda_pkg::ValueW-1:0] value_i,
  output logic                                busy,
  output logic                                strobe_o,
  output logic        [sitda_pkg::CharW-1:0]  char_code_o,
  output logic                                last_char_o
);
  import sitda_pkg::*;

  state_e             state_q, state_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic [ValueW-1:0]  bin_q, bin_d;
  bcd_t               bcd_q, bcd_d, bcd_step;
  logic               neg_q, neg_d;
  logic               strobe_q, strobe_d;
  logic [CharW-1:0]   char_q, char_d;
  logic               last_q, last_d;
  logic [3:0]         top_digit;
  logic [ValueW-1:0]  magnitude;
  logic               accept;

  assign accept    = start && (state_q == StIdle);
  assign top_digit = bcd_q[BcdW-1 -: 4];

  // Two's complement negate; the most negative value maps to itself, which
  // read unsigned is exactly its magnitude.
  assign magnitude = value_i[ValueW-1] ? (~value_i + 1'b1) : value_i;

  sitda_bcd_step u_step (
    .bcd_i     (bcd_q),
    .bin_msb_i (bin_q[ValueW-1]),
    .bcd_o     (bcd_step)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) state_d = StConv;
      end
      StConv: begin
        if (bit_cnt_q == BitCntW'(ValueW - 1)) state_d = StSkip;
      end
      StSkip: begin
        if (top_digit != 4'd0 || dig_cnt_q == DigCntW'(1)) begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: state_d = StEmit;
      StEmit: begin
        if (dig_cnt_q == DigCntW'(1)) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and result outputs.
  always_comb begin
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    strobe_d  = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          bin_d     = magnitude;
          bcd_d     = '0;
          neg_d     = value_i[ValueW-1];
          bit_cnt_d = '0;
        end
      end
      StConv: begin
        // Advance one input bit through the shared BCD step.
        bcd_d     = bcd_step;
        bin_d     = {bin_q[ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        dig_cnt_d = DigCntW'(BcdDigits);
      end
      StSkip: begin
        // Drop a leading zero digit, but always keep the units digit.
        if (top_digit == 4'd0 && dig_cnt_q != DigCntW'(1)) begin
          bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - 1'b1;
        end
      end
      StSign: begin
        strobe_d = 1'b1;
        char_d   = CharMinus;
        last_d   = 1'b0;
      end
      StEmit: begin
        strobe_d  = 1'b1;
        char_d    = CharZero + {{(CharW-4){1'b0}}, top_digit};
        last_d    = (dig_cnt_q == DigCntW'(1));
        bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
        dig_cnt_d = dig_cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
      strobe_q  <= strobe_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy        = (state_q != StIdle);
  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

// File: rtl/sitda_bcd_step.sv
// One shift-and-add-3 step of the binary to BCD converter.
// Depends on sitda_pkg for the BCD word type.
module sitda_bcd_step (
  input  sitda_pkg::bcd_t bcd_i,
  input  logic            bin_msb_i,
  output sitda_pkg::bcd_t bcd_o
);
  import sitda_pkg::*;

  bcd_t adj;

  // Bump every digit of five or more by three, then shift in the next binary bit.
  always_comb begin
    for (int k = 0; k < BcdDigits; k++) begin
      if (bcd_i[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_i[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_i[4*k +: 4];
      end
    end
  end

  assign bcd_o = {adj[BcdW-2:0], bin_msb_i};

endmodule

// File: rtl/sitda_checker.sv
// Port-level assertions for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sitda_pkg for widths and character codes.
module sitda_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               strobe_o,
  input logic [sitda_pkg::CharW-1:0]        char_code_o,
  input logic                               last_char_o
);
  import sitda_pkg::*;

  // Every character is a minus sign or a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (char_code_o == CharMinus) ||
                 (char_code_o >= CharZero && char_code_o <= CharZero + 7'd9))
    else $error("character outside sign and digit set");

  // A minus sign never ends the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && char_code_o == CharMinus) |-> !last_char_o)
    else $error("minus sign flagged as last character");

  // Characters of one number come out back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_char_o) |=> strobe_o)
    else $error("gap inside a number's text");

  // An accepted word makes the block busy and silent in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !strobe_o))
    else $error("accept not followed by busy conversion");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .strobe_o    (strobe_o),
  .char_code_o (char_code_o),
  .last_char_o (last_char_o)
);

// File: bench/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Self-checking bench for signed_int_to_decimal_ascii: drives signed words, predicts the
// decimal ASCII text of each one and checks every strobed character. Depends on sitda_pkg.
module tb_signed_int_to_decimal_ascii;
  import sitda_pkg::*;

  localparam int Radix        = 10;
  localparam int NumRandom    = 410;
  localparam int IdlePct      = 17;
  localparam int CalmFirst    = 150;    // words in [CalmFirst, CalmLast) go back to back
  localparam int CalmLast     = 250;
  localparam int DrainCycles  = 60;     // idle time after the last character to catch any stray strobe
  localparam int CycleLimit   = 400000;

  typedef logic signed [ValueW-1:0] word_t;

  // One character of the expected text, as the block should strobe it.
  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  logic  clk_i   = 1'b0;
  logic  rst_ni  = 1'b0;
  logic  start   = 1'b0;
  word_t value_i = '0;
  logic  busy;
  logic  strobe_o;
  logic  [CharW-1:0] char_code_o;
  logic  last_char_o;

  word_t      words_to_send[$];
  text_char_t text_due[$];
  int         words_sent = 0;
  int         mismatches = 0;
  int         cycles     = 0;

  signed_int_to_decimal_ascii i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .value_i     (value_i),
    .busy        (busy),
    .strobe_o    (strobe_o),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Append the text of one word to the expected characters: a minus sign for
  // negatives, then the digits of the magnitude, most significant first. A
  // 64-bit magnitude keeps the most negative word exact.
  task automatic queue_decimal_text(input word_t word);
    longint   mag;
    int       digits[$];
    if (word < 0) begin
      mag = -longint'(word);
      text_due.push_back('{code: CharMinus, last: 1'b0});
    end else begin
      mag = longint'(word);
    end
    do begin
      digits.push_front(int'(mag % Radix));
      mag = mag / Radix;
    end while (mag != 0);
    foreach (digits[i])
      text_due.push_back('{code: CharZero + CharW'(digits[i]), last: (i == digits.size() - 1)});
  endtask

  // Random word: half fully random bits, half with a uniformly chosen digit
  // count so that short texts show up as often as long ones.
  function automatic word_t random_word();
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    if ($urandom_range(0, 1) == 0)
      return word_t'($urandom);
    ndig = $urandom_range(1, Radix);
    lo   = (ndig == 1) ? 0 : 1;
    hi   = 1;
    for (int i = 0; i < ndig; i++) begin
      if (i < ndig - 1) lo = lo * Radix;
      hi = hi * Radix;
    end
    if (ndig == 1) lo = 0;
    hi = hi - 1;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    mag = lo + longint'($urandom_range(0, int'(hi - lo)));
    // Allow the one magnitude that only exists negated.
    if (ndig == Radix && $urandom_range(0, 63) == 0) return word_t'(32'h8000_0000);
    return ($urandom_range(0, 1) != 0) ? word_t'(-mag) : word_t'(mag);
  endfunction

  // Driver: a word is taken at an edge with start high and busy low. Hold
  // start and value while the block is busy, otherwise advance to the next
  // pending word or idle at random. Outside the calm stretch about one
  // decision in six is an idle cycle.
  always @(posedge clk_i) begin : driver
    logic taken;
    logic idle_ok;
    if (rst_ni) begin
      taken   = start && !busy;
      idle_ok = (words_sent < CalmFirst) || (words_sent >= CalmLast);
      if (taken) begin
        queue_decimal_text(value_i);
        words_sent++;
      end
      if (start && !taken) begin
        // hold the word until the block takes it
      end else if (words_to_send.size() == 0 ||
                   (idle_ok && $urandom_range(0, 99) < IdlePct)) begin
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        value_i <= words_to_send.pop_front();
      end
    end
  end

  // Monitor: the receiver cannot stall, so every strobed cycle is one
  // character. Compare it against the oldest expected character.
  always @(posedge clk_i) begin : monitor
    text_char_t due;
    if (rst_ni && strobe_o) begin
      if (text_due.size() == 0) begin
        $error("unexpected character: char_code %0d last_char %0b", char_code_o, last_char_o);
        mismatches++;
      end else begin
        due = text_due.pop_front();
        if (char_code_o !== due.code) begin
          $error("char_code: expected %0d, got %0d", due.code, char_code_o);
          mismatches++;
        end
        if (last_char_o !== due.last) begin
          $error("last_char: expected %0b, got %0b", due.last, last_char_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    // Directed words: zero, single digits, digit-count boundaries, both
    // extremes of the range and the most negative word, alternating bits.
    words_to_send.push_back(word_t'(0));
    words_to_send.push_back(word_t'(1));
    words_to_send.push_back(word_t'(-1));
    words_to_send.push_back(word_t'(9));
    words_to_send.push_back(word_t'(-9));
    words_to_send.push_back(word_t'(10));
    words_to_send.push_back(word_t'(-10));
    words_to_send.push_back(word_t'(99));
    words_to_send.push_back(word_t'(100));
    words_to_send.push_back(word_t'(-100));
    words_to_send.push_back(word_t'(999999999));
    words_to_send.push_back(word_t'(1000000000));
    words_to_send.push_back(word_t'(-1000000000));
    words_to_send.push_back(word_t'(32'h7FFF_FFFF));
    words_to_send.push_back(word_t'(32'h7FFF_FFFE));
    words_to_send.push_back(word_t'(32'h8000_0000));
    words_to_send.push_back(word_t'(32'h8000_0001));
    words_to_send.push_back(word_t'(32'h5555_5555));
    words_to_send.push_back(word_t'(32'hAAAA_AAAA));
    words_to_send.push_back(word_t'(1234567890));
    words_to_send.push_back(word_t'(-1234567890));
    words_to_send.push_back(word_t'(1000000001));
    for (int i = 0; i < NumRandom; i++)
      words_to_send.push_back(random_word());

    // Hold reset, then release it on a rising edge.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every word is taken and every character has come out,
    // then give the block time to show any stray strobe.
    @(posedge clk_i);
    while (words_to_send.size() != 0 || start) @(posedge clk_i);
    while (text_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && text_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
